@@ rtl/rft_pkg.sv @@
`default_nettype none
package rft_pkg;
    localparam int TableDepth = 64;
    localparam int OffsetBits = 48;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [2:0] ST_LOADED  = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_OVERLAP = 3'd3;
    localparam logic [2:0] ST_HIT     = 3'd4;
    localparam logic [2:0] ST_STRADDLE = 3'd5;
    localparam logic [2:0] ST_MISS    = 3'd6;
    localparam logic [2:0] ST_OUTSIDE = 3'd7;

    localparam logic [1:0] CLS_PRIMARY = 2'd0;
    localparam logic [1:0] CLS_RAM     = 2'd1;
    localparam logic [1:0] CLS_VRAM    = 2'd2;
    localparam logic [1:0] CLS_TAIL    = 2'd3;
    localparam logic [2:0] NO_CLASS    = 3'd4;

    localparam logic [1:0] BK_PRIMARY = 2'd0;
    localparam logic [1:0] BK_PRELOAD = 2'd1;
    localparam logic [1:0] BK_TAIL    = 2'd2;
    localparam logic [1:0] BK_RAM     = 2'd3;

    localparam logic [2:0] REG_VRAM_RAM = 3'd0;
    localparam logic [2:0] REG_SRC_SIZE = 3'd1;
    localparam logic [2:0] REG_TLIMIT   = 3'd2;
    localparam logic [2:0] REG_PRE_SIZE = 3'd3;
    localparam logic [2:0] REG_TAIL_SIZE = 3'd4;
    localparam logic [2:0] REG_PRI_SIZE = 3'd5;
endpackage
`default_nettype wire

@@ rtl/rft_if.sv @@
`default_nettype none
interface rft_in_if #(parameter int OFS_W = 48);
    logic             valid;
    logic             ready;
    logic [1:0]       mode;
    logic [OFS_W-1:0] range_start;
    logic [OFS_W-1:0] range_length;
    logic [OFS_W-1:0] shard_position;
    logic [1:0]       placement;
    logic [15:0]      tensor_id;
    modport source (output valid, mode, range_start, range_length, shard_position,
                    placement, tensor_id, input ready);
    modport sink (input valid, mode, range_start, range_length, shard_position,
                  placement, tensor_id, output ready);
endinterface

interface rft_out_if #(parameter int OFS_W = 48);
    logic             valid;
    logic             ready;
    logic [2:0]       status;
    logic [2:0]       placement_out;
    logic [1:0]       backing;
    logic [OFS_W-1:0] translated_address;
    logic [15:0]      tensor_out;
    modport source (output valid, status, placement_out, backing, translated_address,
                    tensor_out, input ready);
    modport sink (input valid, status, placement_out, backing, translated_address,
                  tensor_out, output ready);
endinterface
`default_nettype wire

@@ rtl/range_fragment_translator.sv @@
`default_nettype none
// Sorted range table built as a row of cells. On capture every cell compares
// the key at once and the match (a one-hot pick over the row) and insert
// position (the count of below flags) are registered; then the selected entry
// is checked, the result is registered, and a load shifts the cells above the
// insert point up by one. A new input is taken when none is being evaluated
// and the result register is empty or being drained. Table contents are not
// cleared; a clear only zeroes the fill count.
module range_fragment_translator
    import rft_pkg::*;
#(
    parameter int TABLE_DEPTH = TableDepth,
    parameter int OFFSET_BITS = OffsetBits
)(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    rft_in_if.sink                      in_ch,
    rft_out_if.source                   out_ch,
    input  wire logic                   cfg_we,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [OFFSET_BITS-1:0] cfg_data
);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int OW = OFFSET_BITS;

    // configuration
    logic          vram_ram_reg;
    logic [OW-1:0] src_size_reg, pre_size_reg, tail_win_reg, pri_size_reg;
    logic [16:0]   tlimit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vram_ram_reg  <= 1'b0;
            src_size_reg  <= '0;
            tlimit_reg    <= 17'd1;
            pre_size_reg  <= '0;
            tail_win_reg  <= '0;
            pri_size_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_VRAM_RAM:  vram_ram_reg  <= cfg_data[0];
                REG_SRC_SIZE:  src_size_reg  <= cfg_data;
                REG_TLIMIT:    tlimit_reg    <= 17'(cfg_data);
                REG_PRE_SIZE:  pre_size_reg  <= cfg_data;
                REG_TAIL_SIZE: tail_win_reg  <= cfg_data;
                REG_PRI_SIZE:  pri_size_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // captured transaction
    logic          busy_reg, busy_next;
    logic [1:0]    mode_reg;
    logic [OW-1:0] st_reg, len_reg, sh_reg;
    logic [1:0]    cls_reg;
    logic [15:0]   tid_reg;
    logic [CW-1:0] count_reg;

    logic          out_valid_reg;
    logic [2:0]    o_status_reg, o_cls_reg;
    logic [1:0]    o_bk_reg;
    logic [OW-1:0] o_addr_reg;
    logic [15:0]   o_tid_reg;

    logic accept, out_free;
    assign out_free   = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !busy_reg && out_free;
    assign accept     = in_ch.valid && in_ch.ready;

    // cell row
    logic [OW-1:0] c_start [TABLE_DEPTH];
    logic [OW-1:0] c_len   [TABLE_DEPTH];
    logic [OW-1:0] c_sh    [TABLE_DEPTH];
    logic [1:0]    c_cls   [TABLE_DEPTH];
    logic [15:0]   c_tid   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] below, contain, occ, shift_v, wr_v;

    logic do_insert;
    logic [CW-1:0] ins_pos_reg;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        assign occ[g]     = CW'(g) < count_reg;
        assign shift_v[g] = do_insert && (CW'(g) > ins_pos_reg) && (CW'(g) <= count_reg);
        assign wr_v[g]    = do_insert && (CW'(g) == ins_pos_reg);
        rft_cell #(.OFS_W(OW)) u_cell (
            .clk          (clk),
            .occupied     (occ[g]),
            .shift_en     (shift_v[g]),
            .write_en     (wr_v[g]),
            .prev_start   (c_start[(g == 0) ? 0 : g-1]),
            .prev_length  (c_len[(g == 0) ? 0 : g-1]),
            .prev_shard   (c_sh[(g == 0) ? 0 : g-1]),
            .prev_cls     (c_cls[(g == 0) ? 0 : g-1]),
            .prev_tensor  (c_tid[(g == 0) ? 0 : g-1]),
            .key_start    (busy_reg ? st_reg : in_ch.range_start),
            .key_length   (len_reg),
            .key_shard    (sh_reg),
            .key_cls      (cls_reg),
            .key_tensor   (tid_reg),
            .start        (c_start[g]),
            .length       (c_len[g]),
            .shard        (c_sh[g]),
            .cls          (c_cls[g]),
            .tensor       (c_tid[g]),
            .below_key    (below[g]),
            .contains_key (contain[g])
        );
    end

    // below is a thermometer (sorted table): position = count of ones;
    // contain is at most one-hot (entries never overlap).
    logic [CW-1:0] pos_c;
    logic [IW-1:0] hit_idx_c;
    logic          hit_c;
    always_comb
    begin
        pos_c     = '0;
        hit_idx_c = '0;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            if (below[k]) pos_c = CW'(k + 1);
            if (contain[k]) hit_idx_c = IW'(k);
        end
        hit_c = |contain;
    end

    logic [IW-1:0] hit_idx_reg;
    logic          hit_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg    <= in_ch.mode;
            st_reg      <= in_ch.range_start;
            len_reg     <= in_ch.range_length;
            sh_reg      <= in_ch.shard_position;
            cls_reg     <= in_ch.placement;
            tid_reg     <= in_ch.tensor_id;
            ins_pos_reg <= pos_c;
            hit_idx_reg <= hit_idx_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else if (accept)
            hit_reg <= hit_c;
    end

    // evaluate the captured transaction
    logic [OW-1:0] shard_sz, p_st, p_len, n_st, h_st, h_len, h_sh, h_delta, bk_sz;
    logic [1:0]    h_cls;
    logic [15:0]   h_tid;
    logic          has_prev, has_next, bad, ovl, full;
    logic [2:0]    r_status, r_cls;
    logic [1:0]    r_bk;
    logic [OW-1:0] r_addr;
    logic [15:0]   r_tid;
    logic [CW-1:0] count_next;

    always_comb
    begin
        shard_sz = (cls_reg == CLS_TAIL) ? tail_win_reg : pre_size_reg;
        has_prev = ins_pos_reg != '0;
        has_next = ins_pos_reg < count_reg;
        p_st  = c_start[IW'(ins_pos_reg - CW'(1))];
        p_len = c_len[IW'(ins_pos_reg - CW'(1))];
        n_st  = c_start[IW'(ins_pos_reg)];
        bad = (len_reg == '0) || (st_reg > src_size_reg) ||
              (len_reg > src_size_reg - st_reg) || ({1'b0, tid_reg} >= tlimit_reg) ||
              ((cls_reg != CLS_PRIMARY) &&
               ((sh_reg > shard_sz) || (len_reg > shard_sz - sh_reg)));
        ovl = (has_prev && (p_len > st_reg - p_st)) ||
              (has_next && (len_reg > n_st - st_reg));
        full = count_reg >= CW'(TABLE_DEPTH);

        h_st    = c_start[hit_idx_reg];
        h_len   = c_len[hit_idx_reg];
        h_sh    = c_sh[hit_idx_reg];
        h_cls   = c_cls[hit_idx_reg];
        h_tid   = c_tid[hit_idx_reg];
        h_delta = st_reg - h_st;
        bk_sz   = (h_cls == CLS_TAIL) ? tail_win_reg : pre_size_reg;

        r_status  = ST_LOADED;
        r_cls     = NO_CLASS;
        r_bk      = BK_PRIMARY;
        r_addr    = '0;
        r_tid     = '0;
        do_insert = 1'b0;
        count_next = count_reg;

        case (mode_reg)
            MODE_CLEAR: count_next = '0;
            MODE_LOAD:
            begin
                if (bad)       r_status = ST_INVALID;
                else if (ovl)  r_status = ST_OVERLAP;
                else if (full) r_status = ST_FULL;
                else
                begin
                    do_insert  = busy_reg;
                    count_next = count_reg + CW'(1);
                end
            end
            MODE_QUERY:
            begin
                if (!hit_reg) r_status = ST_MISS;
                else if (len_reg > h_len - h_delta) r_status = ST_STRADDLE;
                else
                begin
                    r_cls = {1'b0, h_cls};
                    r_tid = h_tid;
                    if (h_cls == CLS_PRIMARY)
                    begin
                        r_bk = BK_PRIMARY;
                        if ((pri_size_reg == '0) || (st_reg > pri_size_reg) ||
                            (len_reg > pri_size_reg - st_reg))
                            r_status = ST_OUTSIDE;
                        else
                        begin
                            r_status = ST_HIT;
                            r_addr   = st_reg;
                        end
                    end
                    else if ((h_cls == CLS_RAM) || ((h_cls == CLS_VRAM) && vram_ram_reg))
                    begin
                        r_status = ST_HIT;
                        r_bk     = BK_RAM;
                        r_addr   = h_delta;
                    end
                    else
                    begin
                        r_bk = (h_cls == CLS_TAIL) ? BK_TAIL : BK_PRELOAD;
                        if ((bk_sz == '0) || (h_sh > bk_sz) || (h_len > bk_sz - h_sh))
                            r_status = ST_OUTSIDE;
                        else
                        begin
                            r_status = ST_HIT;
                            r_addr   = h_sh + h_delta;
                        end
                    end
                end
            end
            default: r_status = ST_INVALID;
        endcase
        busy_next = accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (busy_reg)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            o_status_reg <= r_status;
            o_cls_reg    <= r_cls;
            o_bk_reg     <= r_bk;
            o_addr_reg   <= r_addr;
            o_tid_reg    <= r_tid;
        end
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.status             = o_status_reg;
    assign out_ch.placement_out      = o_cls_reg;
    assign out_ch.backing            = o_bk_reg;
    assign out_ch.translated_address = o_addr_reg;
    assign out_ch.tensor_out         = o_tid_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("fill count above depth");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !accept)
        else $error("accepted while evaluating");
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> out_valid_reg)
        else $error("result missing");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |=> $stable(count_reg))
        else $error("count moved while idle");
endmodule
`default_nettype wire

@@ rtl/rft_cell.sv @@
`default_nettype none
// One table slot. Compares its entry against the broadcast key and shifts
// up from the lower neighbor on insert.
module rft_cell
    import rft_pkg::*;
#(
    parameter int OFS_W = OffsetBits
)(
    input  wire logic             clk,
    input  wire logic             occupied,
    input  wire logic             shift_en,
    input  wire logic             write_en,
    input  wire logic [OFS_W-1:0] prev_start,
    input  wire logic [OFS_W-1:0] prev_length,
    input  wire logic [OFS_W-1:0] prev_shard,
    input  wire logic [1:0]       prev_cls,
    input  wire logic [15:0]      prev_tensor,
    input  wire logic [OFS_W-1:0] key_start,
    input  wire logic [OFS_W-1:0] key_length,
    input  wire logic [OFS_W-1:0] key_shard,
    input  wire logic [1:0]       key_cls,
    input  wire logic [15:0]      key_tensor,
    output logic [OFS_W-1:0]      start,
    output logic [OFS_W-1:0]      length,
    output logic [OFS_W-1:0]      shard,
    output logic [1:0]            cls,
    output logic [15:0]           tensor,
    output logic                  below_key,
    output logic                  contains_key
);
    logic [OFS_W-1:0] start_reg, length_reg, shard_reg;
    logic [1:0]       cls_reg;
    logic [15:0]      tensor_reg;
    logic [OFS_W-1:0] diff;

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            start_reg  <= key_start;
            length_reg <= key_length;
            shard_reg  <= key_shard;
            cls_reg    <= key_cls;
            tensor_reg <= key_tensor;
        end
        else if (shift_en)
        begin
            start_reg  <= prev_start;
            length_reg <= prev_length;
            shard_reg  <= prev_shard;
            cls_reg    <= prev_cls;
            tensor_reg <= prev_tensor;
        end
    end

    assign diff         = key_start - start_reg;
    assign below_key    = occupied && (start_reg < key_start);
    assign contains_key = occupied && (key_start >= start_reg) && (diff < length_reg);
    assign start  = start_reg;
    assign length = length_reg;
    assign shard  = shard_reg;
    assign cls    = cls_reg;
    assign tensor = tensor_reg;
endmodule
`default_nettype wire

@@ tb/range_fragment_translator_test.sv @@
`default_nettype none
module range_fragment_translator_test;
    import rft_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 20000;

    typedef logic [OffsetBits-1:0] ofs_t;

    // One result transaction as seen on the output channel.
    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  placement_out;
        logic [1:0]  backing;
        ofs_t        translated_address;
        logic [15:0] tensor_out;
    } answer_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    ofs_t cfg_data;

    rft_in_if  #(.OFS_W(OffsetBits)) in_ch ();
    rft_out_if #(.OFS_W(OffsetBits)) out_ch ();

    range_fragment_translator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the table and registers.
    ofs_t        tbl_start [TableDepth];
    ofs_t        tbl_len   [TableDepth];
    ofs_t        tbl_shard [TableDepth];
    logic [1:0]  tbl_cls   [TableDepth];
    logic [15:0] tbl_tensor[TableDepth];
    int          tbl_count;

    logic        vram_from_ram;
    ofs_t        src_size;
    logic [16:0] tensor_lim;
    ofs_t        pre_size;
    ofs_t        tail_win;
    ofs_t        pri_size;

    answer_t pending_answers[$];
    int      mismatches = 0;
    int      failed = 0;
    int      idle_cycles = 0;
    bit      quiet_mode;   // no stalls on either side in the final stretch

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Range [pos, pos+len) lies inside [0, size), without overflow.
    function automatic bit fits_in(ofs_t pos, ofs_t len, ofs_t size);
        return !(pos > size || len > size - pos);
    endfunction

    function automatic logic [2:0] insert_fragment(ofs_t st, ofs_t len, ofs_t sh,
                                                   logic [1:0] cls, logic [15:0] tid);
        int p;
        p = 0;
        if (len == 0 || !fits_in(st, len, src_size) || {1'b0, tid} >= tensor_lim)
            return ST_INVALID;
        if (cls != CLS_PRIMARY &&
            !fits_in(sh, len, (cls == CLS_TAIL) ? tail_win : pre_size))
            return ST_INVALID;
        while (p < tbl_count && tbl_start[p] < st)
            p++;
        if (p > 0 && tbl_len[p-1] > st - tbl_start[p-1])
            return ST_OVERLAP;
        if (p < tbl_count && len > tbl_start[p] - st)
            return ST_OVERLAP;
        if (tbl_count >= TableDepth)
            return ST_FULL;
        for (int i = tbl_count; i > p; i--)
        begin
            tbl_start[i]  = tbl_start[i-1];
            tbl_len[i]    = tbl_len[i-1];
            tbl_shard[i]  = tbl_shard[i-1];
            tbl_cls[i]    = tbl_cls[i-1];
            tbl_tensor[i] = tbl_tensor[i-1];
        end
        tbl_start[p]  = st;
        tbl_len[p]    = len;
        tbl_shard[p]  = sh;
        tbl_cls[p]    = cls;
        tbl_tensor[p] = tid;
        tbl_count++;
        return ST_LOADED;
    endfunction

    function automatic answer_t lookup_range(ofs_t ofs, ofs_t len);
        answer_t a;
        int      i;
        ofs_t    delta;
        ofs_t    size;
        a = '{ST_MISS, NO_CLASS, BK_PRIMARY, '0, '0};
        for (i = 0; i < tbl_count; i++)
            if (ofs >= tbl_start[i] && ofs - tbl_start[i] < tbl_len[i])
                break;
        if (i >= tbl_count)
            return a;
        delta = ofs - tbl_start[i];
        if (len > tbl_len[i] - delta)
        begin
            a.status = ST_STRADDLE;
            return a;
        end
        a.placement_out = {1'b0, tbl_cls[i]};
        a.tensor_out    = tbl_tensor[i];
        if (tbl_cls[i] == CLS_PRIMARY)
        begin
            a.backing = BK_PRIMARY;
            if (pri_size == 0 || !fits_in(ofs, len, pri_size))
                a.status = ST_OUTSIDE;
            else
            begin
                a.status = ST_HIT;
                a.translated_address = ofs;
            end
            return a;
        end
        if (tbl_cls[i] == CLS_RAM || (tbl_cls[i] == CLS_VRAM && vram_from_ram))
        begin
            a.status = ST_HIT;
            a.backing = BK_RAM;
            a.translated_address = delta;
            return a;
        end
        a.backing = (tbl_cls[i] == CLS_TAIL) ? BK_TAIL : BK_PRELOAD;
        size = (tbl_cls[i] == CLS_TAIL) ? tail_win : pre_size;
        if (size == 0 || !fits_in(tbl_shard[i], tbl_len[i], size))
            a.status = ST_OUTSIDE;
        else
        begin
            a.status = ST_HIT;
            a.translated_address = tbl_shard[i] + delta;
        end
        return a;
    endfunction

    function automatic answer_t predict_answer(logic [1:0] mode, ofs_t st, ofs_t len,
                                               ofs_t sh, logic [1:0] cls,
                                               logic [15:0] tid);
        answer_t a;
        a = '{ST_LOADED, NO_CLASS, BK_PRIMARY, '0, '0};
        case (mode)
            MODE_CLEAR: tbl_count = 0;
            MODE_LOAD:  a.status = insert_fragment(st, len, sh, cls, tid);
            MODE_QUERY: a = lookup_range(st, len);
            default:    a.status = ST_INVALID;
        endcase
        return a;
    endfunction

    task automatic random_gap();
        int n;
        if (!quiet_mode && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 14);
            repeat (n) @(posedge clk);
        end
    endtask

    // Drive one input transaction and record its expected answer on acceptance.
    // Valid drops at the accepting edge and the next drive waits for the following edge,
    // which the block spends evaluating anyway.
    task automatic send_item(logic [1:0] mode, ofs_t st, ofs_t len, ofs_t sh,
                             logic [1:0] cls, logic [15:0] tid);
        random_gap();
        in_ch.valid          <= 1'b1;
        in_ch.mode           <= mode;
        in_ch.range_start    <= st;
        in_ch.range_length   <= len;
        in_ch.shard_position <= sh;
        in_ch.placement      <= cls;
        in_ch.tensor_id      <= tid;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_answers.push_back(predict_answer(mode, st, len, sh, cls, tid));
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write enable stays high across back-to-back writes; set_config drops it.
    task automatic write_reg(logic [2:0] idx, ofs_t value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_VRAM_RAM:  vram_from_ram = value[0];
            REG_SRC_SIZE:  src_size      = value;
            REG_TLIMIT:    tensor_lim    = value[16:0];
            REG_PRE_SIZE:  pre_size      = value;
            REG_TAIL_SIZE: tail_win      = value;
            REG_PRI_SIZE:  pri_size      = value;
            default: ;
        endcase
    endtask

    task automatic set_config(logic vr, ofs_t ss, logic [16:0] tl, ofs_t ps, ofs_t ts,
                              ofs_t pw);
        wait_drained();
        write_reg(REG_VRAM_RAM, ofs_t'(vr));
        write_reg(REG_SRC_SIZE, ss);
        write_reg(REG_TLIMIT, ofs_t'(tl));
        write_reg(REG_PRE_SIZE, ps);
        write_reg(REG_TAIL_SIZE, ts);
        write_reg(REG_PRI_SIZE, pw);
        cfg_we <= 1'b0;
    endtask

    function automatic ofs_t rand_ofs();
        return ofs_t'({$urandom(), $urandom()});
    endfunction

    // Extremes of fields, every mode and class, each reject reason but a full table.
    task automatic test_directed();
        ofs_t maxv;
        maxv = '1;
        set_config(1'b0, 48'h1000, 17'd16, 48'h800, 48'h400, 48'h900);
        send_item(MODE_QUERY, 0, 0, 0, CLS_PRIMARY, 0);            // empty table miss
        send_item(MODE_LOAD, 48'h100, 0, 0, CLS_PRIMARY, 0);       // zero length
        send_item(MODE_LOAD, 48'hF00, 48'h200, 0, CLS_PRIMARY, 0); // past source end
        send_item(MODE_LOAD, maxv, maxv, maxv, CLS_TAIL, 16'hFFFF);
        send_item(MODE_LOAD, 48'h100, 48'h10, 0, CLS_RAM, 16);      // tensor at limit
        send_item(MODE_LOAD, 48'h100, 48'h10, 48'h7F8, CLS_RAM, 1); // past shard
        send_item(MODE_LOAD, 48'h100, 48'h100, 0, CLS_PRIMARY, 3);
        send_item(MODE_LOAD, 48'h100, 48'h10, 0, CLS_PRIMARY, 3);  // equal start
        send_item(MODE_LOAD, 48'h1F0, 48'h20, 0, CLS_PRIMARY, 3);  // overlaps previous
        send_item(MODE_LOAD, 48'h0F0, 48'h20, 0, CLS_PRIMARY, 3);  // overlaps next
        send_item(MODE_LOAD, 48'h200, 48'h100, 48'h10, CLS_RAM, 5);
        send_item(MODE_LOAD, 48'h300, 48'h100, 48'h700, CLS_VRAM, 6);
        send_item(MODE_LOAD, 48'h400, 48'h100, 48'h300, CLS_TAIL, 15);
        send_item(MODE_LOAD, 48'h800, 48'h800, 48'h0, CLS_PRIMARY, 0);
        send_item(MODE_QUERY, 48'h180, 48'h80, 0, CLS_PRIMARY, 0); // hit at end
        send_item(MODE_QUERY, 48'h180, 48'h81, 0, CLS_PRIMARY, 0); // straddle
        send_item(MODE_QUERY, 48'h250, 0, 0, CLS_PRIMARY, 0);      // zero length hit
        send_item(MODE_QUERY, 48'h310, 48'h10, 0, CLS_PRIMARY, 0); // vram preload
        send_item(MODE_QUERY, 48'h410, 48'h10, 0, CLS_PRIMARY, 0); // tail
        send_item(MODE_QUERY, 48'h8F0, 48'h20, 0, CLS_PRIMARY, 0); // outside primary
        send_item(MODE_QUERY, 48'h700, 4, 0, CLS_PRIMARY, 0);      // gap miss
        send_item(2'd3, maxv, maxv, maxv, CLS_TAIL, 16'hFFFF);      // unknown mode
        set_config(1'b1, 48'h1000, 17'd16, 48'h800, 0, 0);
        send_item(MODE_QUERY, 48'h310, 48'h10, 0, CLS_PRIMARY, 0); // vram from RAM
        send_item(MODE_QUERY, 48'h410, 48'h10, 0, CLS_PRIMARY, 0); // tail unmapped
        send_item(MODE_QUERY, 48'h110, 48'h10, 0, CLS_PRIMARY, 0); // primary unmapped
        send_item(MODE_CLEAR, maxv, maxv, maxv, CLS_TAIL, 16'hFFFF);
        send_item(MODE_QUERY, 48'h110, 0, 0, CLS_PRIMARY, 0);
    endtask

    // Fill the table to depth, then push two more loads.
    task automatic test_table_full();
        set_config(1'b0, '1, 17'd65536, '1, '1, '1);
        send_item(MODE_CLEAR, 0, 0, 0, CLS_PRIMARY, 0);
        for (int i = 0; i <= TableDepth; i++)
            send_item(MODE_LOAD, ofs_t'((TableDepth - i) * 64), 64, 0, CLS_PRIMARY,
                      16'(i));
        send_item(MODE_LOAD, 48'hFFFF_0000, 16, 0, CLS_PRIMARY, 16'hFFFF);
        send_item(MODE_QUERY, 48'd100, 48'd10, 0, CLS_PRIMARY, 0);
    endtask

    // Random fragments on a coarse grid with random content, mostly well formed.
    task automatic send_random(int count);
        ofs_t st, len, sh;
        logic [1:0] mode;
        int k;
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(0, 99);
            if (k < 2)
                mode = MODE_CLEAR;
            else if (k < 4)
                mode = 2'd3;
            else if (k < 50)
                mode = MODE_LOAD;
            else
                mode = MODE_QUERY;
            if ($urandom_range(0, 9) == 0)
            begin
                st  = rand_ofs();
                len = rand_ofs();
                sh  = rand_ofs();
            end
            else
            begin
                st  = ofs_t'($urandom_range(0, 255)) * 64 + ofs_t'($urandom_range(0, 63));
                len = ofs_t'($urandom_range(0, 200));
                sh  = ofs_t'($urandom_range(0, 300)) * 16;
            end
            send_item(mode, st, len, sh, 2'($urandom), 16'($urandom_range(0, 40)));
        end
    endtask

    task automatic test_random();
        set_config(1'b0, 48'h4000, 17'd32, 48'h1000, 48'h1000, 48'h3000);
        send_random(90);
        // hold off until every answer has come in
        wait_drained();
        send_random(20);
        set_config(1'b1, 48'h3800, 17'd1, 48'h800, 48'h2000, 48'h4000);
        send_random(80);
        set_config(1'b0, 48'h4000, 17'd65536, 0, 48'h500, 0);
        send_random(80);
        set_config(1'b1, '1, 17'd40, '1, '1, '1);
        quiet_mode = 1'b1;
        send_random(85);
    endtask

    // Output ready with random stall bursts.
    initial
    begin
        int n;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            out_ch.ready <= 1'b1;
            @(posedge clk);
            if (!quiet_mode && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 14);
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    // Compare each accepted result with the oldest expected answer.
    always @(posedge clk)
    begin
        answer_t seen;
        answer_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            seen = '{out_ch.status, out_ch.placement_out, out_ch.backing,
                     out_ch.translated_address, out_ch.tensor_out};
            if (pending_answers.size() == 0)
            begin
                failed = 1;
                if (mismatches < 10)
                    $display("unexpected transaction: %h", seen);
                mismatches++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (seen !== want)
                begin
                    failed = 1;
                    if (mismatches < 10)
                        $display({"mismatch: exp st=%0d cls=%0d bk=%0d adr=%h t=%h,",
                                  " act st=%0d cls=%0d bk=%0d adr=%h t=%h"},
                                 want.status, want.placement_out, want.backing,
                                 want.translated_address, want.tensor_out,
                                 seen.status, seen.placement_out, seen.backing,
                                 seen.translated_address, seen.tensor_out);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted transaction.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        quiet_mode = 1'b0;
        tbl_count = 0;
        vram_from_ram = 1'b0;
        src_size = '0;
        tensor_lim = 17'd1;
        pre_size = '0;
        tail_win = '0;
        pri_size = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_VRAM_RAM;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_CLEAR;
        in_ch.range_start = '0;
        in_ch.range_length = '0;
        in_ch.shard_position = '0;
        in_ch.placement = CLS_PRIMARY;
        in_ch.tensor_id = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        test_random();
        wait_drained();
        repeat (10) @(posedge clk);
        if (!failed && pending_answers.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
rtl/rft_pkg.sv
rtl/rft_if.sv
rtl/rft_cell.sv
rtl/range_fragment_translator.sv
tb/range_fragment_translator_test.sv
